### hw/rtl/gtned_pkg.sv
// Shared constants, register codes and helpers for the geodetic to NED converter.
// No dependencies.
package gtned_pkg;

  localparam int unsigned ANGLE_FRAC_BITS = 29;
  localparam int unsigned TRIG_FRAC_BITS  = 30;
  localparam int unsigned MM_FRAC         = 16;
  localparam int unsigned K_FRAC          = 8;
  localparam int unsigned PROD_W          = 62;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // mm * 2^K_FRAC: 1.5*a*e2, 0.5*a + 0.25*a*e2, 0.75*a*e2
  localparam logic signed [39:0] K_AE2_3_2 = 40'sd16395906320;
  localparam logic signed [40:0] K_D_BASE  = 41'sd819134187053;
  localparam logic signed [39:0] K_AE2_3_4 = 40'sd8197953160;

  localparam logic [30:0] COS_RESET = 31'd1073741824;
  localparam logic [32:0] RPV_RESET = 33'd6378137000;
  localparam logic [32:0] RMER_RESET = 33'd6335439327;

  typedef enum logic [2:0] {
    REG_ORIGIN_LAT = 3'd0,
    REG_ORIGIN_LON = 3'd1,
    REG_ORIGIN_ALT = 3'd2,
    REG_COS_LAT    = 3'd3,
    REG_SIN_LAT    = 3'd4,
    REG_PV_RADIUS  = 3'd5,
    REG_MER_RADIUS = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] val;
    logic        clip;
  } sat_t;

  // round mm*2^16 to whole mm (ties away from zero), clip to 32 bits
  function automatic sat_t round_sat(input logic signed [63:0] v);
    logic [63:0]        mag;
    logic [63:0]        r;
    logic signed [49:0] s;
    sat_t               o;
    mag = v[63] ? (~v + 64'd1) : v;
    r   = (mag + (64'd1 << (MM_FRAC - 1))) >> MM_FRAC;
    s   = v[63] ? -$signed({1'b0, r[48:0]}) : $signed({1'b0, r[48:0]});
    if (s > 50'sd2147483647) begin
      o.val  = 32'h7FFF_FFFF;
      o.clip = 1'b1;
    end else if (s < -50'sd2147483648) begin
      o.val  = 32'h8000_0000;
      o.clip = 1'b1;
    end else begin
      o.val  = s[31:0];
      o.clip = 1'b0;
    end
    return o;
  endfunction

endpackage

### hw/rtl/gtned_mul.sv
// Two-stage signed multiply with round-to-nearest (ties away) at a fixed shift.
// Result magnitude clipped to 2^60. Uses gtned_pkg.
module gtned_mul #(
  parameter int unsigned AW    = 32,
  parameter int unsigned BW    = 32,
  parameter int unsigned SHIFT = 0
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [AW-1:0]                  a_i,
  input  logic signed [BW-1:0]                  b_i,
  output logic signed [gtned_pkg::PROD_W-1:0]   p_o
);

  localparam logic [127:0] HALF = (128'd1 << SHIFT) >> 1;
  localparam logic [127:0] LIM  = 128'd1 << 60;

  logic signed [63:0] ax, bx;
  logic [63:0]        ua, ub;
  logic [63:0]        ll_q, lh_q, hl_q, hh_q;
  logic               neg_q;
  logic [127:0]       full, sh;
  logic [60:0]        mag;
  logic signed [gtned_pkg::PROD_W-1:0] p_d, p_q;

  always_comb begin
    ax = 64'(a_i);
    bx = 64'(b_i);
    ua = ax[63] ? (~ax + 64'd1) : ax;
    ub = bx[63] ? (~bx + 64'd1) : bx;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q  <= ua[31:0]  * ub[31:0];
      lh_q  <= ua[31:0]  * ub[63:32];
      hl_q  <= ua[63:32] * ub[31:0];
      hh_q  <= ua[63:32] * ub[63:32];
      neg_q <= a_i[AW-1] ^ b_i[BW-1];
    end
  end

  always_comb begin
    full = {64'd0, ll_q} + ({64'd0, lh_q} << 32) + ({64'd0, hl_q} << 32) + {hh_q, 64'd0};
    sh   = (full + HALF) >> SHIFT;
    mag  = (sh > LIM) ? LIM[60:0] : sh[60:0];
    p_d  = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

### hw/rtl/geodetic_to_local_ned.sv
// Throughput one point per cycle while the output is not stalled.
// Three multiply levels of two stages each set the depth; the whole pipe stalls together
// when a result waits. Reset (async, active low) clears the valid bits and loads the
// origin registers with their defaults. Config writes are always ready.
// Depends on gtned_pkg and gtned_mul.
module geodetic_to_local_ned #(
  parameter int unsigned ANGLE_FRAC_BITS = gtned_pkg::ANGLE_FRAC_BITS,
  parameter int unsigned TRIG_FRAC_BITS  = gtned_pkg::TRIG_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // latitude[30:0], longitude[62:31], altitude[90:63]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // north[31:0], east[63:32], down[95:64]
  output logic        m_axis_tuser,   // saturated
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [32:0] cfg_data_i
);

  localparam int unsigned F  = ANGLE_FRAC_BITS;
  localparam int unsigned T  = TRIG_FRAC_BITS;
  localparam int unsigned MF = gtned_pkg::MM_FRAC;
  localparam int unsigned KF = gtned_pkg::K_FRAC;
  localparam int unsigned PW = gtned_pkg::PROD_W;
  localparam longint PI_Q   = longint'((gtned_pkg::PI_Q60 + (64'd1 << (59 - F))) >> (60 - F));
  localparam longint TWO_PI = 2 * PI_Q;
  localparam int     KMAX   = int'((64'd1 << 33) / TWO_PI) + 2;
  localparam int     NSTG   = 11;

  // config registers
  logic signed [30:0] olat_q;
  logic signed [31:0] olon_q;
  logic signed [27:0] oalt_q;
  logic [30:0]        cosl_q;
  logic signed [31:0] sinl_q;
  logic [32:0]        rpv_q, rmer_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      olat_q <= '0;
      olon_q <= '0;
      oalt_q <= '0;
      cosl_q <= gtned_pkg::COS_RESET;
      sinl_q <= '0;
      rpv_q  <= gtned_pkg::RPV_RESET;
      rmer_q <= gtned_pkg::RMER_RESET;
    end else if (cfg_valid_i) begin
      case (gtned_pkg::reg_idx_e'(cfg_index_i))
        gtned_pkg::REG_ORIGIN_LAT: olat_q <= cfg_data_i[30:0];
        gtned_pkg::REG_ORIGIN_LON: olon_q <= cfg_data_i[31:0];
        gtned_pkg::REG_ORIGIN_ALT: oalt_q <= cfg_data_i[27:0];
        gtned_pkg::REG_COS_LAT:    cosl_q <= cfg_data_i[30:0];
        gtned_pkg::REG_SIN_LAT:    sinl_q <= cfg_data_i[31:0];
        gtned_pkg::REG_PV_RADIUS:  rpv_q  <= cfg_data_i;
        gtned_pkg::REG_MER_RADIUS: rmer_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [31:0] cp;
  logic signed [33:0] rn, rm, rd;
  assign cp = $signed({1'b0, cosl_q});
  assign rn = $signed({1'b0, rpv_q})  + 34'(oalt_q);
  assign rm = $signed({1'b0, rmer_q}) + 34'(oalt_q);
  assign rd = $signed({1'b0, rpv_q})  - 34'(oalt_q);

  // pipeline control
  logic [NSTG:1] vld_q;
  logic          en;
  assign en            = !vld_q[NSTG] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-1:1], s_axis_tvalid};
    end
  end

  // stage 1: differences
  logic signed [31:0] dphi_q [1:7];
  logic signed [32:0] dl_q;
  logic signed [28:0] dh_q [1:9];
  logic signed [31:0] dlam_q [2:4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dphi_q[1] <= 32'($signed(s_axis_tdata[30:0])) - 32'(olat_q);
      dl_q      <= 33'($signed(s_axis_tdata[62:31])) - 33'(olon_q);
      dh_q[1]   <= 29'($signed(s_axis_tdata[90:63])) - 29'(oalt_q);
    end
  end

  // stage 2: longitude wrap into [-pi, pi)
  logic signed [35:0] wx, cand, wt;
  always_comb begin
    wx = 36'(dl_q) + 36'(PI_Q);
    wt = '0;
    for (int k = -KMAX; k <= KMAX; k++) begin
      cand = wx - 36'(longint'(k) * TWO_PI);
      if (cand >= 36'sd0 && cand < 36'(TWO_PI)) begin
        wt = cand;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dlam_q[2] <= 32'(wt - 36'(PI_Q));
      dlam_q[3] <= dlam_q[2];
      dlam_q[4] <= dlam_q[3];
      for (int i = 2; i <= 7; i++) dphi_q[i] <= dphi_q[i-1];
      for (int i = 2; i <= 9; i++) dh_q[i] <= dh_q[i-1];
    end
  end

  // level 1 products, operands at stage 2, results at stage 4
  logic signed [PW-1:0] cdl, sdp, cs, ss, cc, dphi2, dlam2, rmdphi;

  gtned_mul #(.AW(32), .BW(32), .SHIFT(T)) u_cdl (.clk_i, .en_i(en),
    .a_i(cp), .b_i(dlam_q[2]), .p_o(cdl));
  gtned_mul #(.AW(32), .BW(32), .SHIFT(T)) u_sdp (.clk_i, .en_i(en),
    .a_i(sinl_q), .b_i(dphi_q[2]), .p_o(sdp));
  gtned_mul #(.AW(32), .BW(32), .SHIFT(T)) u_cs (.clk_i, .en_i(en),
    .a_i(cp), .b_i(sinl_q), .p_o(cs));
  gtned_mul #(.AW(32), .BW(32), .SHIFT(T)) u_ss (.clk_i, .en_i(en),
    .a_i(sinl_q), .b_i(sinl_q), .p_o(ss));
  gtned_mul #(.AW(32), .BW(32), .SHIFT(T)) u_cc (.clk_i, .en_i(en),
    .a_i(cp), .b_i(cp), .p_o(cc));
  gtned_mul #(.AW(32), .BW(32), .SHIFT(F)) u_dphi2 (.clk_i, .en_i(en),
    .a_i(dphi_q[2]), .b_i(dphi_q[2]), .p_o(dphi2));
  gtned_mul #(.AW(32), .BW(32), .SHIFT(F)) u_dlam2 (.clk_i, .en_i(en),
    .a_i(dlam_q[2]), .b_i(dlam_q[2]), .p_o(dlam2));
  gtned_mul #(.AW(34), .BW(32), .SHIFT(F - MF)) u_rmdphi (.clk_i, .en_i(en),
    .a_i(rm), .b_i(dphi_q[2]), .p_o(rmdphi));

  // level 2, operands at stage 4, results at stage 6
  logic signed [PW-1:0] e1, sdl, e3, kcs, ssdh, rncs, kcc, rdcc;

  gtned_mul #(.AW(34), .BW(PW), .SHIFT(F - MF)) u_e1 (.clk_i, .en_i(en),
    .a_i(rn), .b_i(cdl), .p_o(e1));
  gtned_mul #(.AW(PW), .BW(32), .SHIFT(F)) u_sdl (.clk_i, .en_i(en),
    .a_i(sdp), .b_i(dlam_q[4]), .p_o(sdl));
  gtned_mul #(.AW(PW), .BW(29), .SHIFT(F - MF)) u_e3 (.clk_i, .en_i(en),
    .a_i(cdl), .b_i(dh_q[4]), .p_o(e3));
  gtned_mul #(.AW(40), .BW(PW), .SHIFT(T)) u_kcs (.clk_i, .en_i(en),
    .a_i(gtned_pkg::K_AE2_3_2), .b_i(cs), .p_o(kcs));
  gtned_mul #(.AW(PW), .BW(29), .SHIFT(T - MF)) u_ssdh (.clk_i, .en_i(en),
    .a_i(ss), .b_i(dh_q[4]), .p_o(ssdh));
  gtned_mul #(.AW(34), .BW(PW), .SHIFT(T + 1 - MF)) u_rncs (.clk_i, .en_i(en),
    .a_i(rn), .b_i(cs), .p_o(rncs));
  gtned_mul #(.AW(40), .BW(PW), .SHIFT(T)) u_kcc (.clk_i, .en_i(en),
    .a_i(gtned_pkg::K_AE2_3_4), .b_i(cc), .p_o(kcc));
  gtned_mul #(.AW(34), .BW(PW), .SHIFT(T + 1 - MF)) u_rdcc (.clk_i, .en_i(en),
    .a_i(rd), .b_i(cc), .p_o(rdcc));

  // delays and stage 7 operand register
  logic signed [PW-1:0] dphi2_q [5:7];
  logic signed [PW-1:0] dlam2_q [5:7];
  logic signed [PW-1:0] rmdphi_q [5:9];
  logic signed [PW-1:0] e1_q [7:9];
  logic signed [PW-1:0] e3_q [7:9];
  logic signed [PW-1:0] sdl_q, kcs_q, ssdh_q, rncs_q, rdcc_q;
  logic signed [63:0]   cd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dphi2_q[5]  <= dphi2;
      dlam2_q[5]  <= dlam2;
      rmdphi_q[5] <= rmdphi;
      for (int i = 6; i <= 7; i++) begin
        dphi2_q[i] <= dphi2_q[i-1];
        dlam2_q[i] <= dlam2_q[i-1];
      end
      for (int i = 6; i <= 9; i++) rmdphi_q[i] <= rmdphi_q[i-1];
      e1_q[7] <= e1;
      e3_q[7] <= e3;
      for (int i = 8; i <= 9; i++) begin
        e1_q[i] <= e1_q[i-1];
        e3_q[i] <= e3_q[i-1];
      end
      sdl_q  <= sdl;
      kcs_q  <= kcs;
      ssdh_q <= ssdh;
      rncs_q <= rncs;
      rdcc_q <= rdcc;
      cd_q   <= 64'(gtned_pkg::K_D_BASE) - 64'(kcc) + (64'(oalt_q) <<< (KF - 1));
    end
  end

  // level 3, operands at stage 7, results at stage 9
  logic signed [PW-1:0] e2, n2, n3, n4, d2, d3;

  gtned_mul #(.AW(34), .BW(PW), .SHIFT(F - MF)) u_e2 (.clk_i, .en_i(en),
    .a_i(rm), .b_i(sdl_q), .p_o(e2));
  gtned_mul #(.AW(PW), .BW(PW), .SHIFT(F + KF - MF)) u_n2 (.clk_i, .en_i(en),
    .a_i(kcs_q), .b_i(dphi2_q[7]), .p_o(n2));
  gtned_mul #(.AW(PW), .BW(32), .SHIFT(F)) u_n3 (.clk_i, .en_i(en),
    .a_i(ssdh_q), .b_i(dphi_q[7]), .p_o(n3));
  gtned_mul #(.AW(PW), .BW(PW), .SHIFT(F)) u_n4 (.clk_i, .en_i(en),
    .a_i(rncs_q), .b_i(dlam2_q[7]), .p_o(n4));
  gtned_mul #(.AW(64), .BW(PW), .SHIFT(F + KF - MF)) u_d2 (.clk_i, .en_i(en),
    .a_i(cd_q), .b_i(dphi2_q[7]), .p_o(d2));
  gtned_mul #(.AW(PW), .BW(PW), .SHIFT(F)) u_d3 (.clk_i, .en_i(en),
    .a_i(rdcc_q), .b_i(dlam2_q[7]), .p_o(d3));

  // stage 10: sums, stage 11: round and saturate
  logic signed [63:0] e_q, n_q, d_q;
  gtned_pkg::sat_t    sn, se, sd;
  logic [95:0]        out_q;
  logic               sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q <= 64'(e1_q[9]) - 64'(e2) + 64'(e3_q[9]);
      n_q <= 64'(rmdphi_q[9]) + 64'(n2) + 64'(n3) + 64'(n4);
      d_q <= -(64'(dh_q[9]) <<< MF) + 64'(d2) + 64'(d3);
    end
  end

  always_comb begin
    sn = gtned_pkg::round_sat(n_q);
    se = gtned_pkg::round_sat(e_q);
    sd = gtned_pkg::round_sat(d_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {sd.val, se.val, sn.val};
      sat_q <= sn.clip | se.clip | sd.clip;
    end
  end

  assign m_axis_tvalid = vld_q[NSTG];
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = sat_q;

endmodule

### hw/rtl/gtned_chk.sv
// Port-level checks for geodetic_to_local_ned, attached by bind.
// Depends only on the top-level ports.
module gtned_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [32:0] cfg_data_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken during stall");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind geodetic_to_local_ned gtned_chk u_gtned_chk (.*);

### dv/tb_geodetic_to_local_ned.sv
// Testbench for geodetic_to_local_ned: random and directed points against a built-in
// predictor of the second-order flat-earth expansion, across several origin settings.
// Depends on gtned_pkg and the geodetic_to_local_ned RTL.
`timescale 1ns / 1ps

module tb_geodetic_to_local_ned;

  localparam int          LIMIT      = 300000;
  localparam logic [2:0]  REG_NONE   = 3'd7;
  localparam longint      LAT_MAX    = 843314856;
  localparam longint      LON_MAX    = 1686629713;
  localparam longint      ALT_MIN    = -10000000;
  localparam longint      ALT_MAX    = 100000000;
  localparam longint      TRIG_ONE   = 1073741824;
  localparam longint      LIM60      = longint'(1) << 60;

  typedef struct {
    logic [30:0] lat;
    logic [31:0] lon;
    logic [27:0] alt;
  } point_t;

  typedef struct {
    logic [31:0] north;
    logic [31:0] east;
    logic [31:0] down;
    logic        sat;
  } ned_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [32:0] cfg_data_i = '0;

  logic [30:0] org_lat;
  logic [31:0] org_lon;
  logic [27:0] org_alt;
  logic [30:0] cos_lat;
  logic [31:0] sin_lat;
  logic [32:0] pv_rad;
  logic [32:0] mer_rad;

  point_t pending_pts[$];
  ned_t   expected_ned[$];
  int     errors = 0;
  int     cycles = 0;
  bit     quiet = 1'b0;
  bit     req_taken = 1'b0;
  int     src_gap = 0;
  int     snk_gap = 0;

  geodetic_to_local_ned dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic longint mul_round(longint a, longint b, int s);
    logic [63:0]  ua, ub;
    logic [127:0] p;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ua  = a < 0 ? -a : a;
    ub  = b < 0 ? -b : b;
    p   = {64'd0, ua} * {64'd0, ub};
    if (s > 0) p = (p + (128'd1 << (s - 1))) >> s;
    if (p > 128'(LIM60)) p = 128'(LIM60);
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [31:0] clip32(longint v, ref logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic ned_t predict_ned(point_t p);
    longint pi_q, h0, cp, sp, rn, rm, rd, dphi, dl, dh, t, dlam;
    longint cdl, sdp, cs, ss, cc, dphi2, dlam2, cd, e, n, d;
    ned_t   r;
    logic   sat;
    pi_q = longint'((gtned_pkg::PI_Q60 + (64'd1 << 30)) >> 31);
    h0   = longint'($signed(org_alt));
    cp   = longint'(cos_lat);
    sp   = longint'($signed(sin_lat));
    rn   = longint'(pv_rad) + h0;
    rm   = longint'(mer_rad) + h0;
    rd   = longint'(pv_rad) - h0;
    dphi = longint'($signed(p.lat)) - longint'($signed(org_lat));
    dl   = longint'($signed(p.lon)) - longint'($signed(org_lon));
    dh   = longint'($signed(p.alt)) - h0;
    t = (dl + pi_q) % (2 * pi_q);
    if (t < 0) t += 2 * pi_q;
    dlam = t - pi_q;
    cdl   = mul_round(cp, dlam, 30);
    sdp   = mul_round(sp, dphi, 30);
    cs    = mul_round(cp, sp, 30);
    ss    = mul_round(sp, sp, 30);
    cc    = mul_round(cp, cp, 30);
    dphi2 = mul_round(dphi, dphi, 29);
    dlam2 = mul_round(dlam, dlam, 29);
    e = mul_round(rn, cdl, 13) - mul_round(rm, mul_round(sdp, dlam, 29), 13)
      + mul_round(cdl, dh, 13);
    n = mul_round(rm, dphi, 13)
      + mul_round(mul_round(gtned_pkg::K_AE2_3_2, cs, 30), dphi2, 21)
      + mul_round(mul_round(ss, dh, 14), dphi, 29)
      + mul_round(mul_round(rn, cs, 15), dlam2, 29);
    cd = gtned_pkg::K_D_BASE - mul_round(gtned_pkg::K_AE2_3_4, cc, 30) + h0 * 128;
    d = -dh * 65536 + mul_round(cd, dphi2, 21)
      + mul_round(mul_round(rd, cc, 15), dlam2, 29);
    sat     = 1'b0;
    r.north = clip32(mul_round(n, 1, 16), sat);
    r.east  = clip32(mul_round(e, 1, 16), sat);
    r.down  = clip32(mul_round(d, 1, 16), sat);
    r.sat   = sat;
    return r;
  endfunction

  // input side: accept, predict; output side: compare against the prediction
  always @(posedge clk_i) begin
    cycles++;
    req_taken = s_axis_tvalid && s_axis_tready;
    if (req_taken) begin
      expected_ned.push_back(predict_ned(pending_pts.pop_front()));
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_ned.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
      end else begin
        ned_t x;
        x = expected_ned.pop_front();
        if (m_axis_tdata[31:0] !== x.north) begin
          errors++;
          $display("%0t: north exp %0d got %0d", $time, $signed(x.north),
                   $signed(m_axis_tdata[31:0]));
        end
        if (m_axis_tdata[63:32] !== x.east) begin
          errors++;
          $display("%0t: east exp %0d got %0d", $time, $signed(x.east),
                   $signed(m_axis_tdata[63:32]));
        end
        if (m_axis_tdata[95:64] !== x.down) begin
          errors++;
          $display("%0t: down exp %0d got %0d", $time, $signed(x.down),
                   $signed(m_axis_tdata[95:64]));
        end
        if (m_axis_tuser !== x.sat) begin
          errors++;
          $display("%0t: saturated exp %0b got %0b", $time, x.sat, m_axis_tuser);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("tb_geodetic_to_local_ned: errors");
      $finish;
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !req_taken) begin
        s_axis_tvalid <= 1'b1;
      end else if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pts.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, pending_pts[0].alt, pending_pts[0].lon, pending_pts[0].lat};
        if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 4);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) snk_gap = $urandom_range(1, 4);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [32:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gtned_pkg::REG_ORIGIN_LAT: org_lat = val[30:0];
      gtned_pkg::REG_ORIGIN_LON: org_lon = val[31:0];
      gtned_pkg::REG_ORIGIN_ALT: org_alt = val[27:0];
      gtned_pkg::REG_COS_LAT:    cos_lat = val[30:0];
      gtned_pkg::REG_SIN_LAT:    sin_lat = val[31:0];
      gtned_pkg::REG_PV_RADIUS:  pv_rad  = val;
      gtned_pkg::REG_MER_RADIUS: mer_rad = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (pending_pts.size() == 0 && expected_ned.size() == 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_origin(longint lat, longint lon, longint alt, longint c, longint s,
                            longint nr, longint mr);
    wait_idle();
    write_reg(gtned_pkg::REG_ORIGIN_LAT, 33'(lat));
    write_reg(gtned_pkg::REG_ORIGIN_LON, 33'(lon));
    write_reg(gtned_pkg::REG_ORIGIN_ALT, 33'(alt));
    write_reg(gtned_pkg::REG_COS_LAT, 33'(c));
    write_reg(gtned_pkg::REG_SIN_LAT, 33'(s));
    write_reg(gtned_pkg::REG_PV_RADIUS, 33'(nr));
    write_reg(gtned_pkg::REG_MER_RADIUS, 33'(mr));
  endtask

  function automatic longint rnd_in(longint lo, longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  task automatic push_point(longint lat, longint lon, longint alt);
    point_t p;
    p.lat = lat[30:0];
    p.lon = lon[31:0];
    p.alt = alt[27:0];
    pending_pts.push_back(p);
  endtask

  task automatic random_points(int count);
    int m;
    for (int i = 0; i < count; i++) begin
      m = $urandom_range(0, 9);
      if (m == 0) begin
        push_point($urandom, $urandom, $urandom);
      end else if (m == 1) begin
        push_point(rnd_in(-LAT_MAX, LAT_MAX), rnd_in(-LON_MAX, LON_MAX),
                   rnd_in(ALT_MIN, ALT_MAX));
      end else begin
        push_point(longint'($signed(org_lat)) + rnd_in(-1000000, 1000000),
                   longint'($signed(org_lon)) + rnd_in(-1000000, 1000000),
                   rnd_in(ALT_MIN, ALT_MAX / 10));
      end
    end
  endtask

  initial begin
    longint pi_q;
    org_lat = '0;
    org_lon = '0;
    org_alt = '0;
    cos_lat = gtned_pkg::COS_RESET;
    sin_lat = '0;
    pv_rad  = gtned_pkg::RPV_RESET;
    mer_rad = gtned_pkg::RMER_RESET;
    pi_q = longint'((gtned_pkg::PI_Q60 + (64'd1 << 30)) >> 31);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: origin, field extremes, wrap at +-pi, all-ones and all-zero bits
    push_point(0, 0, 0);
    push_point(LAT_MAX, 0, 0);
    push_point(-LAT_MAX, 0, 0);
    push_point(0, LON_MAX, 0);
    push_point(0, -LON_MAX, 0);
    push_point(0, pi_q, 0);
    push_point(0, -pi_q, 0);
    push_point(0, pi_q - 1, 0);
    push_point(0, 0, ALT_MAX);
    push_point(0, 0, ALT_MIN);
    push_point(LAT_MAX, LON_MAX, ALT_MAX);
    push_point(-LAT_MAX, -LON_MAX, ALT_MIN);
    push_point(-1, -1, -1);
    push_point(1, 1, 1);
    push_point(31'h3FFF_FFFF, 32'h7FFF_FFFF, 28'h7FF_FFFF);
    push_point(31'h4000_0000, 32'h8000_0000, 28'h800_0000);
    push_point(1000, 1000, 500);
    push_point(-1000, 1000, -500);
    random_points(300);

    set_origin(LAT_MAX, LON_MAX, ALT_MAX, 0, TRIG_ONE, 6399593626, 6399593626);
    push_point(LAT_MAX, -LON_MAX, ALT_MIN);
    push_point(-LAT_MAX, LON_MAX, ALT_MAX);
    random_points(300);

    set_origin(-LAT_MAX, -LON_MAX, ALT_MIN, TRIG_ONE, -TRIG_ONE, 6378137000, 6335439327);
    push_point(LAT_MAX, LON_MAX, ALT_MAX);
    random_points(300);

    set_origin(rnd_in(-LAT_MAX, LAT_MAX), rnd_in(-LON_MAX, LON_MAX), rnd_in(ALT_MIN, ALT_MAX),
               rnd_in(0, TRIG_ONE), rnd_in(-TRIG_ONE, TRIG_ONE),
               rnd_in(6378137000, 6399593626), rnd_in(6335439327, 6399593626));
    random_points(300);

    // unchecked register contents, plus an unused index that must be ignored
    set_origin($urandom, $urandom, $urandom, $urandom, $urandom,
               {$urandom, 1'b1}, {$urandom, 1'b0});
    write_reg(REG_NONE, {$urandom, 1'b1});
    random_points(300);

    set_origin(rnd_in(-LAT_MAX, LAT_MAX), rnd_in(-LON_MAX, LON_MAX), rnd_in(ALT_MIN, ALT_MAX),
               rnd_in(0, TRIG_ONE), rnd_in(-TRIG_ONE, TRIG_ONE),
               rnd_in(6378137000, 6399593626), rnd_in(6335439327, 6399593626));
    random_points(100);
    wait (pending_pts.size() == 0 && expected_ned.size() == 0);
    quiet = 1'b1;
    random_points(200);

    wait (pending_pts.size() == 0 && expected_ned.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_geodetic_to_local_ned: clean");
    end else begin
      $display("tb_geodetic_to_local_ned: errors");
    end
    $finish;
  end

endmodule
